### rtl/mcfe_pkg.sv
// ----------------------------------------------------------------------------
// mcfe_pkg: shared types and constants of the motor command frame encoder
// Holds the command codes, queue entry type, register layout and the fixed
// frame bytes used by the front end, the queue, the back end and the top.
// ----------------------------------------------------------------------------
package mcfe_pkg;

  typedef enum logic [1:0] {
    CMD_RESET   = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2,
    CMD_CONTROL = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_CAN_ID       = 2'd0;
  localparam logic [1:0] REG_POS_LIMIT    = 2'd1;
  localparam logic [1:0] REG_SPEED_LIMIT  = 2'd2;
  localparam logic [1:0] REG_TORQUE_LIMIT = 2'd3;

  localparam logic [10:0] RST_CAN_ID       = 11'd1;
  localparam logic [30:0] RST_POS_LIMIT    = 31'd819200;
  localparam logic [30:0] RST_SPEED_LIMIT  = 31'd1966080;
  localparam logic [30:0] RST_TORQUE_LIMIT = 31'd655360;

  localparam logic [31:0] KP_SPAN = 32'd32768000;
  localparam logic [31:0] KD_SPAN = 32'd327680;

  localparam logic [55:0] FIXED_HEAD   = 56'hff_ffff_ffff_ffff;
  localparam logic [7:0]  BYTE_RESET   = 8'hfb;
  localparam logic [7:0]  BYTE_ENABLE  = 8'hfc;
  localparam logic [7:0]  BYTE_DISABLE = 8'hfd;

  localparam logic [2:0] FLD_POS    = 3'd0;
  localparam logic [2:0] FLD_SPEED  = 3'd1;
  localparam logic [2:0] FLD_KP     = 3'd2;
  localparam logic [2:0] FLD_KD     = 3'd3;
  localparam logic [2:0] FLD_TORQUE = 3'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic        [24:0] kp;
    logic        [18:0] kd;
    logic signed [31:0] torque;
  } item_t;

  typedef struct packed {
    logic [10:0] can_id;
    logic [30:0] pos_limit;
    logic [30:0] speed_limit;
    logic [30:0] torque_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_status_t;

  typedef struct packed {
    logic drive_enabled;
  } front_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } back_status_t;

endpackage

### rtl/mcfe_if.sv
// ----------------------------------------------------------------------------
// mcfe_cmd_if / mcfe_frame_if: command and frame channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface mcfe_cmd_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  command;
  logic signed [31:0] target_position;
  logic signed [31:0] target_speed;
  logic        [24:0] stiffness_gain;
  logic        [18:0] damping_gain;
  logic signed [31:0] feedforward_torque;

  modport source (output valid, command, target_position, target_speed, stiffness_gain,
                  damping_gain, feedforward_torque, input ready);
  modport sink (input valid, command, target_position, target_speed, stiffness_gain,
                damping_gain, feedforward_torque, output ready);
endinterface

interface mcfe_frame_if;
  logic        valid;
  logic        ready;
  logic [10:0] frame_id;
  logic [63:0] frame_payload;

  modport source (output valid, frame_id, frame_payload, input ready);
  modport sink (input valid, frame_id, frame_payload, output ready);
endinterface

### rtl/mcfe_front.sv
// ----------------------------------------------------------------------------
// mcfe_front: command intake and classification
// Accepts command transactions, tracks the drive enable flag and forwards
// every command that produces a frame into the work queue.
// ----------------------------------------------------------------------------
module mcfe_front
  import mcfe_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  mcfe_cmd_if.sink      in_chan,
  input  q_status_t     q_st,
  output logic          push,
  output item_t         push_item,
  output front_status_t front_st
);

  logic drive_enabled_r, drive_enabled_nxt;
  logic accept;
  cmd_t cmd;

  assign in_chan.ready = !q_st.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign cmd           = cmd_t'(in_chan.command);

  assign push_item.cmd      = cmd;
  assign push_item.position = in_chan.target_position;
  assign push_item.speed    = in_chan.target_speed;
  assign push_item.kp       = in_chan.stiffness_gain;
  assign push_item.kd       = in_chan.damping_gain;
  assign push_item.torque   = in_chan.feedforward_torque;

  assign push = accept && !((cmd == CMD_CONTROL) && !drive_enabled_r);

  always_comb begin
    drive_enabled_nxt = drive_enabled_r;
    if (accept) begin
      case (cmd)
        CMD_ENABLE:  drive_enabled_nxt = 1'b1;
        CMD_DISABLE: drive_enabled_nxt = 1'b0;
        default:     drive_enabled_nxt = drive_enabled_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_enabled_r <= 1'b0;
    end else begin
      drive_enabled_r <= drive_enabled_nxt;
    end
  end

  assign front_st.drive_enabled = drive_enabled_r;

endmodule

### rtl/mcfe_queue.sv
// ----------------------------------------------------------------------------
// mcfe_queue: work queue between front end and back end
// A short first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
module mcfe_queue
  import mcfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     pop_item,
  output q_status_t q_st
);

  item_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_st.count = count_r;
  assign q_st.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_st.empty = (count_r == '0);
  assign do_push    = push && !q_st.full;
  assign do_pop     = pop && !q_st.empty;
  assign pop_item   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/mcfe_back.sv
// ----------------------------------------------------------------------------
// mcfe_back: frame builder
// Takes commands from the work queue, quantizes the five control fields one
// after another with a shared bit-serial divider and holds the finished frame
// in an output register.
// ----------------------------------------------------------------------------
module mcfe_back
  import mcfe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_regs_t    cfg,
  input  q_status_t    q_st,
  input  item_t        pop_item,
  output logic         pop,
  mcfe_frame_if.source out_chan,
  output back_status_t back_st
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_PREP = 6'b000100,
    S_DIV  = 6'b001000,
    S_ACC  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  item_t              item_r, item_nxt;
  logic [2:0]         field_r, field_nxt;
  logic signed [33:0] d_r, d_nxt;
  logic [31:0]        span_r, span_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [15:0]        lo_r, lo_nxt;
  logic [15:0]        q_r, q_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [15:0]        code_r, code_nxt;
  logic [63:0]        payload_r, payload_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [10:0]        out_id_r, out_id_nxt;
  logic [63:0]        out_payload_r, out_payload_nxt;

  logic               wide;
  logic [30:0]        lim_raw;
  logic [30:0]        lim;
  logic signed [31:0] x_sym;
  logic [47:0]        numer;
  logic [32:0]        trial;
  logic               slot_free;

  assign wide      = (field_r == FLD_POS);
  assign slot_free = !out_valid_r || out_chan.ready;
  assign pop       = (state_r == S_IDLE) && !q_st.empty;

  always_comb begin
    case (field_r)
      FLD_POS:   begin lim_raw = cfg.pos_limit;    x_sym = item_r.position; end
      FLD_SPEED: begin lim_raw = cfg.speed_limit;  x_sym = item_r.speed;    end
      default:   begin lim_raw = cfg.torque_limit; x_sym = item_r.torque;   end
    endcase
    lim = (lim_raw == '0) ? 31'd1 : lim_raw;
  end

  always_comb begin
    if (wide) begin
      numer = {d_r[31:0], 16'b0} - {16'b0, d_r[31:0]};
    end else begin
      numer = {4'b0, d_r[31:0], 12'b0} - {16'b0, d_r[31:0]};
    end
  end

  assign trial = {rem_r, lo_r[15]};

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    field_nxt       = field_r;
    d_nxt           = d_r;
    span_nxt        = span_r;
    rem_nxt         = rem_r;
    lo_nxt          = lo_r;
    q_nxt           = q_r;
    cnt_nxt         = cnt_r;
    code_nxt        = code_r;
    payload_nxt     = payload_r;
    out_valid_nxt   = out_valid_r;
    out_id_nxt      = out_id_r;
    out_payload_nxt = out_payload_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (!q_st.empty) begin
          item_nxt  = pop_item;
          field_nxt = FLD_POS;
          case (pop_item.cmd)
            CMD_RESET: begin
              payload_nxt = {FIXED_HEAD, BYTE_RESET};
              state_nxt   = S_DONE;
            end
            CMD_ENABLE: begin
              payload_nxt = {FIXED_HEAD, BYTE_ENABLE};
              state_nxt   = S_DONE;
            end
            CMD_DISABLE: begin
              payload_nxt = {FIXED_HEAD, BYTE_DISABLE};
              state_nxt   = S_DONE;
            end
            default: begin
              payload_nxt = '0;
              state_nxt   = S_LOAD;
            end
          endcase
        end
      end
      S_LOAD: begin
        case (field_r)
          FLD_KP: begin
            d_nxt    = {9'b0, item_r.kp};
            span_nxt = KP_SPAN;
          end
          FLD_KD: begin
            d_nxt    = {15'b0, item_r.kd};
            span_nxt = KD_SPAN;
          end
          default: begin
            d_nxt    = {{2{x_sym[31]}}, x_sym} + {3'b0, lim};
            span_nxt = {lim, 1'b0};
          end
        endcase
        state_nxt = S_PREP;
      end
      S_PREP: begin
        if (d_r[33] || (d_r == '0)) begin
          code_nxt  = '0;
          state_nxt = S_ACC;
        end else if (d_r[32:0] >= {1'b0, span_r}) begin
          code_nxt  = wide ? 16'hffff : 16'h0fff;
          state_nxt = S_ACC;
        end else begin
          q_nxt = '0;
          if (wide) begin
            rem_nxt = numer[47:16];
            lo_nxt  = numer[15:0];
            cnt_nxt = 4'd15;
          end else begin
            rem_nxt = numer[43:12];
            lo_nxt  = {numer[11:0], 4'b0};
            cnt_nxt = 4'd11;
          end
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, span_r}) begin
          rem_nxt = 32'(trial - {1'b0, span_r});
          q_nxt   = {q_r[14:0], 1'b1};
        end else begin
          rem_nxt = trial[31:0];
          q_nxt   = {q_r[14:0], 1'b0};
        end
        lo_nxt = {lo_r[14:0], 1'b0};
        if (cnt_r == '0) begin
          code_nxt  = q_nxt;
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_ACC: begin
        if (wide) begin
          payload_nxt = {payload_r[47:0], code_r};
        end else begin
          payload_nxt = {payload_r[51:0], code_r[11:0]};
        end
        if (field_r == FLD_TORQUE) begin
          state_nxt = S_DONE;
        end else begin
          field_nxt = field_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_id_nxt      = cfg.can_id;
          out_payload_nxt = payload_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r        <= item_nxt;
    field_r       <= field_nxt;
    d_r           <= d_nxt;
    span_r        <= span_nxt;
    rem_r         <= rem_nxt;
    lo_r          <= lo_nxt;
    q_r           <= q_nxt;
    cnt_r         <= cnt_nxt;
    code_r        <= code_nxt;
    payload_r     <= payload_nxt;
    out_id_r      <= out_id_nxt;
    out_payload_r <= out_payload_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.frame_id      = out_id_r;
  assign out_chan.frame_payload = out_payload_r;

  assign back_st.busy = (state_r != S_IDLE);
  assign back_st.done = (state_r == S_DONE);

endmodule

### rtl/mit_motor_command_frame_encoder.sv
// ----------------------------------------------------------------------------
// mit_motor_command_frame_encoder: MIT-mode motor command frame encoder
// Turns reset, enable, disable and control commands into 8-byte CAN frames.
// ----------------------------------------------------------------------------
// A reset, enable or disable command goes from the two-entry work queue through
// S_DONE into the output register. A control command runs through the shared
// bit-serial divider that quantizes the five fields in turn: each field passes
// through the load, prepare and accumulate steps, plus one quotient bit per
// cycle (16 for position and 12 for the others) unless its value saturates.
// Control commands received while the drive is disabled produce no frame.
// Commands keep being accepted while the queue has room; a finished frame waits
// in the output register, and the next one is held in S_DONE until it is free.
module mit_motor_command_frame_encoder
  import mcfe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  mcfe_cmd_if.sink     in_chan,
  mcfe_frame_if.source out_chan,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_wdata
);

  cfg_regs_t     cfg_r, cfg_nxt;
  q_status_t     q_st;
  front_status_t front_st;
  back_status_t  back_st;
  logic          push, pop;
  item_t         push_item, pop_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_CAN_ID:       cfg_nxt.can_id       = cfg_wdata[10:0];
        REG_POS_LIMIT:    cfg_nxt.pos_limit    = cfg_wdata;
        REG_SPEED_LIMIT:  cfg_nxt.speed_limit  = cfg_wdata;
        REG_TORQUE_LIMIT: cfg_nxt.torque_limit = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.can_id       <= RST_CAN_ID;
      cfg_r.pos_limit    <= RST_POS_LIMIT;
      cfg_r.speed_limit  <= RST_SPEED_LIMIT;
      cfg_r.torque_limit <= RST_TORQUE_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mcfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_st      (q_st),
    .push      (push),
    .push_item (push_item),
    .front_st  (front_st)
  );

  mcfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_st      (q_st)
  );

  mcfe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_st     (q_st),
    .pop_item (pop_item),
    .pop      (pop),
    .out_chan (out_chan),
    .back_st  (back_st)
  );

  a_enable_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.command == CMD_ENABLE))
    |=> front_st.drive_enabled)
    else $error("enable transaction did not set the drive enable flag");

  a_frame_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(back_st.done))
    else $error("frame presented without the back end finishing it");

  a_queue_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_st.empty && !back_st.busy) |=> back_st.busy)
    else $error("back end stayed idle with work queued");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_st.count <= QCNT_W'(QUEUE_DEPTH)) && (q_st.full != q_st.empty || q_st.count != '0))
    else $error("work queue count out of range");

endmodule

### test/tb_mit_motor_command_frame_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mit_motor_command_frame_encoder: self-checking bench for the frame encoder
// A directed table and then random command streams are sent over several
// register settings while both channels stall at random in most phases. Every
// frame is checked against its table entry or an in-bench MIT-mode encoder.
// ----------------------------------------------------------------------------
module tb_mit_motor_command_frame_encoder
  import mcfe_pkg::*;
();

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 125;
  localparam int DIRECTED_ROWS = 21;

  typedef enum logic [1:0] {
    EXP_PREDICT = 2'd0,
    EXP_NONE    = 2'd1,
    EXP_TYPED   = 2'd2
  } exp_kind_t;

  typedef struct packed {
    item_t       stim;
    exp_kind_t   kind;
    logic [63:0] frame;
  } directed_row_t;

  typedef struct packed {
    logic [10:0] id;
    logic [63:0] payload;
  } frame_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_wdata;

  mcfe_cmd_if   in_chan ();
  mcfe_frame_if out_chan ();

  mit_motor_command_frame_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  frame_t      pending_frames[$];
  int          fail_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [10:0] can_id;
  logic [30:0] pos_limit;
  logic [30:0] spd_limit;
  logic [30:0] trq_limit;
  logic        motor_enabled;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{CMD_CONTROL, 32'h0, 32'h0, 25'h0, 19'h0, 32'h0}, EXP_NONE, 64'h0},
    '{'{CMD_RESET, 32'h0, 32'h0, 25'h0, 19'h0, 32'h0}, EXP_TYPED, 64'hffff_ffff_ffff_fffb},
    '{'{CMD_DISABLE, 32'h0, 32'h0, 25'h0, 19'h0, 32'h0}, EXP_TYPED, 64'hffff_ffff_ffff_fffd},
    '{'{CMD_ENABLE, 32'h0, 32'h0, 25'h0, 19'h0, 32'h0}, EXP_TYPED, 64'hffff_ffff_ffff_fffc},
    '{'{CMD_ENABLE, 32'hffff_ffff, 32'hffff_ffff, 25'h1ff_ffff, 19'h7_ffff, 32'hffff_ffff},
      EXP_TYPED, 64'hffff_ffff_ffff_fffc},
    '{'{CMD_CONTROL, 32'h7fff_ffff, 32'h7fff_ffff, 25'h1ff_ffff, 19'h7_ffff, 32'h7fff_ffff},
      EXP_TYPED, 64'hffff_ffff_ffff_ffff},
    '{'{CMD_CONTROL, 32'h8000_0000, 32'h8000_0000, 25'h0, 19'h0, 32'h8000_0000},
      EXP_TYPED, 64'h0},
    '{'{CMD_CONTROL, 32'h0, 32'h0, 25'h0, 19'h0, 32'h0}, EXP_PREDICT, 64'h0},
    '{'{CMD_CONTROL, 32'h000c_8000, 32'h001e_0000, 25'd32768000, 19'd327680, 32'h000a_0000},
      EXP_TYPED, 64'hffff_ffff_ffff_ffff},
    '{'{CMD_CONTROL, 32'hfff3_8000, 32'hffe2_0000, 25'h1, 19'h1, 32'hfff6_0000},
      EXP_TYPED, 64'h0},
    '{'{CMD_CONTROL, 32'h0001_0000, 32'hffff_0000, 25'd32768001, 19'd327681, 32'h0},
      EXP_PREDICT, 64'h0},
    '{'{CMD_CONTROL, 32'h1, 32'hffff_ffff, 25'd16384000, 19'd163840, 32'h0001_0000},
      EXP_PREDICT, 64'h0},
    '{'{CMD_CONTROL, 32'hfff3_8001, 32'h001d_ffff, 25'd4000, 19'd77, 32'hffff_ffff},
      EXP_PREDICT, 64'h0},
    '{'{CMD_DISABLE, 32'h0, 32'h0, 25'h0, 19'h0, 32'h0}, EXP_TYPED, 64'hffff_ffff_ffff_fffd},
    '{'{CMD_CONTROL, 32'h1234_5678, 32'h0, 25'd1000, 19'd1000, 32'h0}, EXP_NONE, 64'h0},
    '{'{CMD_RESET, 32'h0, 32'h0, 25'h0, 19'h0, 32'h0}, EXP_TYPED, 64'hffff_ffff_ffff_fffb},
    '{'{CMD_CONTROL, 32'h0, 32'h0, 25'h0, 19'h0, 32'h0}, EXP_NONE, 64'h0},
    '{'{CMD_ENABLE, 32'h0, 32'h0, 25'h0, 19'h0, 32'h0}, EXP_TYPED, 64'hffff_ffff_ffff_fffc},
    '{'{CMD_RESET, 32'h0, 32'h0, 25'h0, 19'h0, 32'h0}, EXP_TYPED, 64'hffff_ffff_ffff_fffb},
    '{'{CMD_CONTROL, 32'h0003_4567, 32'hfff8_9abc, 25'd9000000, 19'd200000, 32'hfffc_0001},
      EXP_PREDICT, 64'h0},
    '{'{CMD_CONTROL, 32'hffff_8000, 32'h0000_8000, 25'h1ff_ffff, 19'h0, 32'h0004_0000},
      EXP_PREDICT, 64'h0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint quantize_code(longint x, longint lo, longint span, int bits);
    longint top;
    longint num;
    longint q;
    top = (longint'(1) << bits) - 1;
    num = (x - lo) * top;
    if (num <= 0) begin
      return 0;
    end
    q = num / span;
    if (q > top) begin
      q = top;
    end
    return q;
  endfunction

  function automatic longint symmetric_code(logic signed [31:0] x, logic [30:0] limit,
                                            int bits);
    longint bound;
    bound = longint'(limit);
    if (bound == 0) begin
      bound = 1;
    end
    return quantize_code(longint'(x), -bound, 2 * bound, bits);
  endfunction

  function automatic bit encode_frame(input item_t it, output logic [63:0] payload);
    logic [15:0] pos_code;
    logic [11:0] spd_code;
    logic [11:0] kp_code;
    logic [11:0] kd_code;
    logic [11:0] trq_code;
    payload = '0;
    case (it.cmd)
      CMD_RESET: begin
        payload = {FIXED_HEAD, BYTE_RESET};
      end
      CMD_ENABLE: begin
        payload = {FIXED_HEAD, BYTE_ENABLE};
        motor_enabled = 1'b1;
      end
      CMD_DISABLE: begin
        payload = {FIXED_HEAD, BYTE_DISABLE};
        motor_enabled = 1'b0;
      end
      default: begin
        if (!motor_enabled) begin
          return 1'b0;
        end
        pos_code = 16'(symmetric_code(it.position, pos_limit, 16));
        spd_code = 12'(symmetric_code(it.speed, spd_limit, 12));
        kp_code  = 12'(quantize_code(longint'(it.kp), 0, longint'(KP_SPAN), 12));
        kd_code  = 12'(quantize_code(longint'(it.kd), 0, longint'(KD_SPAN), 12));
        trq_code = 12'(symmetric_code(it.torque, trq_limit, 12));
        payload  = {pos_code, spd_code, kp_code, kd_code, trq_code};
      end
    endcase
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_value(logic [30:0] limit);
    longint bound;
    longint reach;
    longint off;
    longint unsigned r;
    bound = (limit == 0) ? 1 : longint'(limit);
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3: return ($urandom_range(0, 1) != 0) ? 32'(bound) : 32'(-bound);
      default: begin
        reach = bound + bound / 8 + 1;
        r = {$urandom, $urandom};
        off = longint'(r % longint'(2 * reach + 1)) - reach;
        if (off > 64'sh7fff_ffff) begin
          off = 64'sh7fff_ffff;
        end
        if (off < -64'sh8000_0000) begin
          off = -64'sh8000_0000;
        end
        return off[31:0];
      end
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.cmd = CMD_CONTROL;
    end else if (pick < 75) begin
      it.cmd = CMD_ENABLE;
    end else if (pick < 85) begin
      it.cmd = CMD_RESET;
    end else begin
      it.cmd = CMD_DISABLE;
    end
    it.position = pick_value(pos_limit);
    it.speed    = pick_value(spd_limit);
    it.torque   = pick_value(trq_limit);
    it.kp = ($urandom_range(0, 4) != 0) ? 25'($urandom_range(0, 32768000)) : 25'($urandom);
    it.kd = ($urandom_range(0, 4) != 0) ? 19'($urandom_range(0, 327680)) : 19'($urandom);
    return it;
  endfunction

  function automatic logic [30:0] random_limit();
    case ($urandom_range(0, 2))
      0: return 31'($urandom_range(1, 32'h7fff_ffff));
      1: return 31'($urandom_range(65536, 100 * 65536));
      default: return 31'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic transmit(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid              <= 1'b1;
    in_chan.command            <= it.cmd;
    in_chan.target_position    <= it.position;
    in_chan.target_speed       <= it.speed;
    in_chan.stiffness_gain     <= it.kp;
    in_chan.damping_gain       <= it.kd;
    in_chan.feedforward_torque <= it.torque;
    @(posedge clk);
    while (!in_chan.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic issue(input item_t it, input exp_kind_t kind, input logic [63:0] frame);
    logic [63:0] payload;
    bit          has_frame;
    transmit(it);
    has_frame = encode_frame(it, payload);
    if (kind == EXP_TYPED) begin
      pending_frames.push_back('{can_id, frame});
    end else if (kind == EXP_PREDICT && has_frame) begin
      pending_frames.push_back('{can_id, payload});
    end
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_registers(input logic [10:0] id, input logic [30:0] pos,
                                 input logic [30:0] spd, input logic [30:0] trq);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CAN_ID;
    cfg_wdata <= {20'h0, id};
    @(posedge clk);
    cfg_index <= REG_POS_LIMIT;
    cfg_wdata <= pos;
    @(posedge clk);
    cfg_index <= REG_SPEED_LIMIT;
    cfg_wdata <= spd;
    @(posedge clk);
    cfg_index <= REG_TORQUE_LIMIT;
    cfg_wdata <= trq;
    @(posedge clk);
    cfg_we    <= 1'b0;
    can_id    = id;
    pos_limit = pos;
    spd_limit = spd;
    trq_limit = trq;
  endtask

  task automatic check_frame();
    frame_t want;
    if (pending_frames.size() == 0) begin
      $error("unexpected frame: frame_id %0h frame_payload %h",
             out_chan.frame_id, out_chan.frame_payload);
      fail_count++;
    end else begin
      want = pending_frames.pop_front();
      if (out_chan.frame_id !== want.id) begin
        $error("frame_id mismatch: expected %0h, actual %0h", want.id, out_chan.frame_id);
        fail_count++;
      end
      if (out_chan.frame_payload !== want.payload) begin
        $error("frame_payload mismatch: expected %h, actual %h",
               want.payload, out_chan.frame_payload);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      check_frame();
    end
    out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    fail_count    = 0;
    send_idle_pct = 8;
    recv_idle_pct = 45;
    can_id        = RST_CAN_ID;
    pos_limit     = RST_POS_LIMIT;
    spd_limit     = RST_SPEED_LIMIT;
    trq_limit     = RST_TORQUE_LIMIT;
    motor_enabled = 1'b0;
    rst_n                      <= 1'b0;
    cfg_we                     <= 1'b0;
    cfg_index                  <= REG_CAN_ID;
    cfg_wdata                  <= '0;
    in_chan.valid              <= 1'b0;
    in_chan.command            <= CMD_RESET;
    in_chan.target_position    <= '0;
    in_chan.target_speed       <= '0;
    in_chan.stiffness_gain     <= '0;
    in_chan.damping_gain       <= '0;
    in_chan.feedforward_torque <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].stim, directed_rows[i].kind, directed_rows[i].frame);
    end
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 45;
      end else if (phase < 4) begin
        send_idle_pct = 45;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: write_registers(11'h000, 31'h0, 31'h0, 31'h0);
        1: write_registers(11'h7ff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
        2: write_registers(11'h001, 31'h1, 31'h1, 31'h1);
        4: write_registers(11'h555, RST_POS_LIMIT, RST_SPEED_LIMIT, RST_TORQUE_LIMIT);
        default: write_registers(11'($urandom), random_limit(), random_limit(),
                                 random_limit());
      endcase
      repeat (PHASE_ITEMS) begin
        issue(random_item(), EXP_PREDICT, 64'h0);
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mcfe_pkg.sv
rtl/mcfe_if.sv
rtl/mcfe_front.sv
rtl/mcfe_queue.sv
rtl/mcfe_back.sv
rtl/mit_motor_command_frame_encoder.sv
test/tb_mit_motor_command_frame_encoder.sv
